// ===== design/eadc_pkg.sv =====
// ----------------------------------------------------------------------------
// eadc_pkg
// Shared types, register map and duty conversion for the edge avoid drive
// controller.
// ----------------------------------------------------------------------------
package eadc_pkg;

    localparam int THR_W   = 12;
    localparam int SPD_W   = 7;
    localparam int TIME_W  = 16;
    localparam int STAMP_W = 32;
    localparam int DUTY_W  = 8;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // register index codes
    localparam logic [2:0] REG_LEFT_THR   = 3'd0;
    localparam logic [2:0] REG_RIGHT_THR  = 3'd1;
    localparam logic [2:0] REG_CRUISE_SPD = 3'd2;
    localparam logic [2:0] REG_REVERSE_SPD = 3'd3;
    localparam logic [2:0] REG_SPIN_SPD   = 3'd4;
    localparam logic [2:0] REG_BACKUP_MS  = 3'd5;
    localparam logic [2:0] REG_TURN_MS    = 3'd6;
    localparam logic [2:0] REG_CORNER_MS  = 3'd7;

    // reset values
    localparam logic [THR_W-1:0]  RST_THR        = 12'd3700;
    localparam logic [SPD_W-1:0]  RST_CRUISE_SPD = 7'd55;
    localparam logic [SPD_W-1:0]  RST_REVERSE_SPD = 7'd55;
    localparam logic [SPD_W-1:0]  RST_SPIN_SPD   = 7'd60;
    localparam logic [TIME_W-1:0] RST_BACKUP_MS  = 16'd300;
    localparam logic [TIME_W-1:0] RST_TURN_MS    = 16'd400;
    localparam logic [TIME_W-1:0] RST_CORNER_MS  = 16'd700;

    localparam logic [SPD_W-1:0] SPD_MAX    = 7'd100;
    // floor(x / 100) as (x * RECIP_100) >> RECIP_SHIFT, exact for x <= 25500
    localparam logic [15:0]      RECIP_100  = 16'd41944;
    localparam int               RECIP_SHIFT = 22;

    typedef enum logic [1:0] {
        MODE_FORWARD = 2'd0,
        MODE_BACKUP  = 2'd1,
        MODE_TURN    = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        SIDE_NONE  = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2,
        SIDE_BOTH  = 2'd3
    } t_side;

    typedef struct packed {
        logic [THR_W-1:0]   left_sample;
        logic [THR_W-1:0]   right_sample;
        logic [STAMP_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic              left_forward;
        logic [DUTY_W-1:0] left_duty;
        logic              right_forward;
        logic [DUTY_W-1:0] right_duty;
        logic [1:0]        drive_mode;
        logic              left_edge_led;
        logic              right_edge_led;
    } t_out_item;

    typedef struct packed {
        logic [THR_W-1:0]  left_thr;
        logic [THR_W-1:0]  right_thr;
        logic [DUTY_W-1:0] cruise_duty;
        logic [DUTY_W-1:0] reverse_duty;
        logic [DUTY_W-1:0] spin_duty;
        logic [TIME_W-1:0] backup_ms;
        logic [TIME_W-1:0] turn_ms;
        logic [TIME_W-1:0] corner_ms;
    } t_cfg_view;

    // percent (clamped to 100) to duty, pct * 255 / 100 floored
    function automatic logic [DUTY_W-1:0] f_duty(input logic [SPD_W-1:0] spd);
        logic [SPD_W-1:0] mag;
        logic [14:0]      scaled;
        logic [30:0]      prod;
        mag    = (spd > SPD_MAX) ? SPD_MAX : spd;
        scaled = {mag, 8'b0} - {8'b0, mag};
        prod   = {16'b0, scaled} * {15'b0, RECIP_100};
        return prod[RECIP_SHIFT +: DUTY_W];
    endfunction

endpackage

// ===== design/eadc_cfg.sv =====
// ----------------------------------------------------------------------------
// eadc_cfg
// Register file behind the APB-style port; keeps raw values for readback and
// the converted duties for the datapath.
// ----------------------------------------------------------------------------
module eadc_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [eadc_pkg::ADDR_W-1:0] paddr,
    input  logic [eadc_pkg::DATA_W-1:0] pwdata,
    output logic [eadc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output eadc_pkg::t_cfg_view        o_cfg
);
    import eadc_pkg::*;

    logic [THR_W-1:0]  r_left_thr;
    logic [THR_W-1:0]  r_right_thr;
    logic [SPD_W-1:0]  r_cruise_spd;
    logic [SPD_W-1:0]  r_reverse_spd;
    logic [SPD_W-1:0]  r_spin_spd;
    logic [TIME_W-1:0] r_backup_ms;
    logic [TIME_W-1:0] r_turn_ms;
    logic [TIME_W-1:0] r_corner_ms;
    logic [DUTY_W-1:0] r_cruise_duty;
    logic [DUTY_W-1:0] r_reverse_duty;
    logic [DUTY_W-1:0] r_spin_duty;

    logic       wr_en;
    logic [2:0] reg_idx;
    logic [DUTY_W-1:0] wr_duty;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];
    assign wr_duty = f_duty(pwdata[SPD_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_thr     <= RST_THR;
            r_right_thr    <= RST_THR;
            r_cruise_spd   <= RST_CRUISE_SPD;
            r_reverse_spd  <= RST_REVERSE_SPD;
            r_spin_spd     <= RST_SPIN_SPD;
            r_backup_ms    <= RST_BACKUP_MS;
            r_turn_ms      <= RST_TURN_MS;
            r_corner_ms    <= RST_CORNER_MS;
            r_cruise_duty  <= f_duty(RST_CRUISE_SPD);
            r_reverse_duty <= f_duty(RST_REVERSE_SPD);
            r_spin_duty    <= f_duty(RST_SPIN_SPD);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_LEFT_THR:    r_left_thr  <= pwdata[THR_W-1:0];
                REG_RIGHT_THR:   r_right_thr <= pwdata[THR_W-1:0];
                REG_CRUISE_SPD: begin
                    r_cruise_spd  <= pwdata[SPD_W-1:0];
                    r_cruise_duty <= wr_duty;
                end
                REG_REVERSE_SPD: begin
                    r_reverse_spd  <= pwdata[SPD_W-1:0];
                    r_reverse_duty <= wr_duty;
                end
                REG_SPIN_SPD: begin
                    r_spin_spd  <= pwdata[SPD_W-1:0];
                    r_spin_duty <= wr_duty;
                end
                REG_BACKUP_MS:   r_backup_ms <= pwdata[TIME_W-1:0];
                REG_TURN_MS:     r_turn_ms   <= pwdata[TIME_W-1:0];
                REG_CORNER_MS:   r_corner_ms <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_LEFT_THR:    prdata = {{(DATA_W-THR_W){1'b0}}, r_left_thr};
            REG_RIGHT_THR:   prdata = {{(DATA_W-THR_W){1'b0}}, r_right_thr};
            REG_CRUISE_SPD:  prdata = {{(DATA_W-SPD_W){1'b0}}, r_cruise_spd};
            REG_REVERSE_SPD: prdata = {{(DATA_W-SPD_W){1'b0}}, r_reverse_spd};
            REG_SPIN_SPD:    prdata = {{(DATA_W-SPD_W){1'b0}}, r_spin_spd};
            REG_BACKUP_MS:   prdata = {{(DATA_W-TIME_W){1'b0}}, r_backup_ms};
            REG_TURN_MS:     prdata = {{(DATA_W-TIME_W){1'b0}}, r_turn_ms};
            REG_CORNER_MS:   prdata = {{(DATA_W-TIME_W){1'b0}}, r_corner_ms};
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.left_thr     = r_left_thr;
        o_cfg.right_thr    = r_right_thr;
        o_cfg.cruise_duty  = r_cruise_duty;
        o_cfg.reverse_duty = r_reverse_duty;
        o_cfg.spin_duty    = r_spin_duty;
        o_cfg.backup_ms    = r_backup_ms;
        o_cfg.turn_ms      = r_turn_ms;
        o_cfg.corner_ms    = r_corner_ms;
    end

    a_duty_zero_iff_speed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cruise_duty == '0) == (r_cruise_spd == '0))
        else $error("cruise duty out of step with cruise speed");

endmodule

// ===== design/eadc_step.sv =====
// ----------------------------------------------------------------------------
// eadc_step
// Mode state and held drive, plus the single-pass step logic that turns one
// registered request into its result.
// ----------------------------------------------------------------------------
module eadc_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  eadc_pkg::t_in_item   i_item,
    input  eadc_pkg::t_cfg_view  i_cfg,
    output eadc_pkg::t_out_item  o_result
);
    import eadc_pkg::*;

    t_mode              r_mode,  n_mode;
    t_side              r_trig,  n_trig;
    logic [STAMP_W-1:0] r_start, n_start;
    logic               r_lfwd,  n_lfwd;
    logic [DUTY_W-1:0]  r_lduty, n_lduty;
    logic               r_rfwd,  n_rfwd;
    logic [DUTY_W-1:0]  r_rduty, n_rduty;

    logic               left_on;
    logic               right_on;
    logic [STAMP_W-1:0] elapsed;
    logic [TIME_W-1:0]  turn_limit;
    logic               spin_nz;
    logic               rev_nz;

    assign left_on    = i_item.left_sample > i_cfg.left_thr;
    assign right_on   = i_item.right_sample > i_cfg.right_thr;
    assign elapsed    = i_item.now_ms - r_start;
    assign turn_limit = (r_trig == SIDE_BOTH) ? i_cfg.corner_ms : i_cfg.turn_ms;
    assign spin_nz    = i_cfg.spin_duty != '0;
    assign rev_nz     = i_cfg.reverse_duty != '0;

    always_comb begin
        n_mode  = r_mode;
        n_trig  = r_trig;
        n_start = r_start;
        n_lfwd  = r_lfwd;
        n_lduty = r_lduty;
        n_rfwd  = r_rfwd;
        n_rduty = r_rduty;
        unique case (r_mode)
            MODE_BACKUP: begin
                n_lfwd  = !rev_nz;
                n_lduty = i_cfg.reverse_duty;
                n_rfwd  = !rev_nz;
                n_rduty = i_cfg.reverse_duty;
                if (elapsed > {{(STAMP_W-TIME_W){1'b0}}, i_cfg.backup_ms}) begin
                    n_mode  = MODE_TURN;
                    n_start = i_item.now_ms;
                end
            end
            MODE_TURN: begin
                n_lduty = i_cfg.spin_duty;
                n_rduty = i_cfg.spin_duty;
                if (r_trig == SIDE_RIGHT) begin
                    n_lfwd = !spin_nz;
                    n_rfwd = 1'b1;
                end else begin
                    n_lfwd = 1'b1;
                    n_rfwd = !spin_nz;
                end
                if (elapsed > {{(STAMP_W-TIME_W){1'b0}}, turn_limit}) begin
                    n_trig  = SIDE_NONE;
                    n_mode  = MODE_FORWARD;
                    n_start = i_item.now_ms;
                end
            end
            default: begin
                if (left_on || right_on) begin
                    n_trig  = (left_on && right_on) ? SIDE_BOTH
                                                    : (left_on ? SIDE_LEFT : SIDE_RIGHT);
                    n_mode  = MODE_BACKUP;
                    n_start = i_item.now_ms;
                end else begin
                    n_mode  = MODE_FORWARD;
                    n_lfwd  = 1'b1;
                    n_lduty = i_cfg.cruise_duty;
                    n_rfwd  = 1'b1;
                    n_rduty = i_cfg.cruise_duty;
                end
            end
        endcase
    end

    always_comb begin
        o_result.left_forward   = n_lfwd;
        o_result.left_duty      = n_lduty;
        o_result.right_forward  = n_rfwd;
        o_result.right_duty     = n_rduty;
        o_result.drive_mode     = n_mode;
        o_result.left_edge_led  = (n_mode != MODE_FORWARD)
                                  && (n_trig == SIDE_LEFT || n_trig == SIDE_BOTH);
        o_result.right_edge_led = (n_mode != MODE_FORWARD)
                                  && (n_trig == SIDE_RIGHT || n_trig == SIDE_BOTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_FORWARD;
            r_trig  <= SIDE_NONE;
            r_start <= '0;
            r_lfwd  <= 1'b1;
            r_lduty <= '0;
            r_rfwd  <= 1'b1;
            r_rduty <= '0;
        end else if (i_advance) begin
            r_mode  <= n_mode;
            r_trig  <= n_trig;
            r_start <= n_start;
            r_lfwd  <= n_lfwd;
            r_lduty <= n_lduty;
            r_rfwd  <= n_rfwd;
            r_rduty <= n_rduty;
        end
    end

    a_trigger_tracks_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_FORWARD) == (r_trig == SIDE_NONE))
        else $error("edge side out of step with mode");

    a_backup_exits_to_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_mode) == MODE_BACKUP && r_mode != MODE_BACKUP) |-> r_mode == MODE_TURN)
        else $error("back up left for a mode other than turn");

    a_forward_drive_on_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && r_mode == MODE_FORWARD && !left_on && !right_on)
        |=> (r_lfwd && r_rfwd && r_lduty == r_rduty))
        else $error("clear forward step did not drive both sides forward");

endmodule

// ===== design/edge_avoid_drive_controller.sv =====
// ----------------------------------------------------------------------------
// edge_avoid_drive_controller
// Edge avoiding drive controller: forward, back up and turn modes driven by
// two reflectance samples and a millisecond timestamp.
// ----------------------------------------------------------------------------
// a request is held in the request register, passes the step logic and is
// registered in the result register, where it waits until it is taken
// throughput: one request per cycle; the step logic is a single pass between
// the two registers, input stalls only while a result waits under stall
// reset: synchronous active low, clears both stages, mode to forward, held
// drive to forward with zero duty and the registers to their defaults
module edge_avoid_drive_controller (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  eadc_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output eadc_pkg::t_out_item         o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [eadc_pkg::ADDR_W-1:0] paddr,
    input  logic [eadc_pkg::DATA_W-1:0] pwdata,
    output logic [eadc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import eadc_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic      advance;
    logic      in_take;
    t_cfg_view cfg;
    t_out_item step_result;

    eadc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    eadc_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in),
        .i_cfg     (cfg),
        .o_result  (step_result)
    );

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_stalled_request_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && i_out_stall) |=> r_in_valid)
        else $error("request dropped while result stage was stalled");

    a_empty_input_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("stall raised with an empty input stage");

    a_stalled_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed or dropped");

endmodule

// ===== dv/eadc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eadc_checker
// Watches the request, response and register ports of the edge avoid drive
// controller, predicts each response from its own copy of the mode state and
// the registers, and compares every response field with the oldest
// prediction. Hands the failure count and the number of outstanding
// predictions to the testbench top.
// ----------------------------------------------------------------------------
module eadc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  eadc_pkg::t_in_item            i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  eadc_pkg::t_out_item           i_out_data,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [eadc_pkg::ADDR_W-1:0]   i_paddr,
    input  logic [eadc_pkg::DATA_W-1:0]   i_pwdata,
    output int                            o_fail_count,
    output int                            o_pending
);
    import eadc_pkg::*;

    logic [THR_W-1:0]   thr_l, thr_r;
    logic [SPD_W-1:0]   spd_cruise, spd_rev, spd_spin;
    logic [TIME_W-1:0]  ms_backup, ms_turn, ms_corner;

    t_mode              mode;
    t_side              trig;
    logic [STAMP_W-1:0] start_ms;
    // {forward, duty} held per side
    logic [DUTY_W:0]    drive_l, drive_r;

    t_out_item          drive_q[$];
    int                 fails;
    int                 n_resp;

    function automatic logic [DUTY_W:0] side_drive(input logic [SPD_W-1:0] pct,
                                                   input logic rev);
        int unsigned mag;
        mag = (pct > SPD_MAX) ? SPD_MAX : pct;
        return {(rev && mag != 0) ? 1'b0 : 1'b1, DUTY_W'(mag * 255 / 100)};
    endfunction

    function automatic string show(input t_out_item r);
        return $sformatf("L fwd %0d duty %0d R fwd %0d duty %0d mode %0d leds %0d%0d",
                         r.left_forward, r.left_duty, r.right_forward, r.right_duty,
                         r.drive_mode, r.left_edge_led, r.right_edge_led);
    endfunction

    task automatic predict_drive(input t_in_item req, output t_out_item want);
        logic               l_hit, r_hit;
        logic [STAMP_W-1:0] elapsed;
        logic [TIME_W-1:0]  limit;
        logic               active;
        l_hit   = req.left_sample > thr_l;
        r_hit   = req.right_sample > thr_r;
        elapsed = req.now_ms - start_ms;
        unique case (mode)
            MODE_BACKUP: begin
                drive_l = side_drive(spd_rev, 1'b1);
                drive_r = side_drive(spd_rev, 1'b1);
                if (elapsed > ms_backup) begin
                    mode     = MODE_TURN;
                    start_ms = req.now_ms;
                end
            end
            MODE_TURN: begin
                drive_l = side_drive(spd_spin, trig == SIDE_RIGHT);
                drive_r = side_drive(spd_spin, trig != SIDE_RIGHT);
                limit   = (trig == SIDE_BOTH) ? ms_corner : ms_turn;
                if (elapsed > limit) begin
                    trig     = SIDE_NONE;
                    mode     = MODE_FORWARD;
                    start_ms = req.now_ms;
                end
            end
            default: begin
                if (l_hit || r_hit) begin
                    // edge step issues no drive command
                    trig     = (l_hit && r_hit) ? SIDE_BOTH :
                               (l_hit ? SIDE_LEFT : SIDE_RIGHT);
                    mode     = MODE_BACKUP;
                    start_ms = req.now_ms;
                end else begin
                    mode    = MODE_FORWARD;
                    drive_l = side_drive(spd_cruise, 1'b0);
                    drive_r = side_drive(spd_cruise, 1'b0);
                end
            end
        endcase
        active              = mode != MODE_FORWARD;
        want.left_forward   = drive_l[DUTY_W];
        want.left_duty      = drive_l[DUTY_W-1:0];
        want.right_forward  = drive_r[DUTY_W];
        want.right_duty     = drive_r[DUTY_W-1:0];
        want.drive_mode     = mode;
        want.left_edge_led  = active && (trig == SIDE_LEFT || trig == SIDE_BOTH);
        want.right_edge_led = active && (trig == SIDE_RIGHT || trig == SIDE_BOTH);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        logic      bad;
        if (!i_rst_n) begin
            thr_l      = RST_THR;
            thr_r      = RST_THR;
            spd_cruise = RST_CRUISE_SPD;
            spd_rev    = RST_REVERSE_SPD;
            spd_spin   = RST_SPIN_SPD;
            ms_backup  = RST_BACKUP_MS;
            ms_turn    = RST_TURN_MS;
            ms_corner  = RST_CORNER_MS;
            mode       = MODE_FORWARD;
            trig       = SIDE_NONE;
            start_ms   = '0;
            drive_l    = {1'b1, {DUTY_W{1'b0}}};
            drive_r    = {1'b1, {DUTY_W{1'b0}}};
            drive_q.delete();
            fails      = 0;
            n_resp     = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                unique case (i_paddr[ADDR_W-1:2])
                    REG_LEFT_THR:    thr_l      = i_pwdata[THR_W-1:0];
                    REG_RIGHT_THR:   thr_r      = i_pwdata[THR_W-1:0];
                    REG_CRUISE_SPD:  spd_cruise = i_pwdata[SPD_W-1:0];
                    REG_REVERSE_SPD: spd_rev    = i_pwdata[SPD_W-1:0];
                    REG_SPIN_SPD:    spd_spin   = i_pwdata[SPD_W-1:0];
                    REG_BACKUP_MS:   ms_backup  = i_pwdata[TIME_W-1:0];
                    REG_TURN_MS:     ms_turn    = i_pwdata[TIME_W-1:0];
                    REG_CORNER_MS:   ms_corner  = i_pwdata[TIME_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (drive_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("response %0d with no request pending: %s",
                                 n_resp, show(i_out_data));
                end else begin
                    want = drive_q.pop_front();
                    bad  = (i_out_data.left_forward   !== want.left_forward)  ||
                           (i_out_data.left_duty      !== want.left_duty)     ||
                           (i_out_data.right_forward  !== want.right_forward) ||
                           (i_out_data.right_duty     !== want.right_duty)    ||
                           (i_out_data.drive_mode     !== want.drive_mode)    ||
                           (i_out_data.left_edge_led  !== want.left_edge_led) ||
                           (i_out_data.right_edge_led !== want.right_edge_led);
                    if (bad) begin
                        fails++;
                        if (fails <= 10)
                            $display("response %0d mismatch\n  exp %s\n  got %s",
                                     n_resp, show(want), show(i_out_data));
                    end
                end
                n_resp++;
            end
            if (i_in_valid && !i_in_stall) begin
                predict_drive(i_in_data, want);
                drive_q.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= drive_q.size();
    end

endmodule

// ===== dv/tb_edge_avoid_drive_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edge_avoid_drive_controller
// Drives sensor requests and register writes into the edge avoid drive
// controller: directed mode walks under reset, extreme and clamped settings,
// then random phases of mostly well-formed edge sequences with random
// settings, random request gaps and response stalls. Checking is done by
// eadc_checker; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_edge_avoid_drive_controller;
    import eadc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_REQS  = 290;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    t_in_item           in_data   = '0;
    logic               out_stall = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [ADDR_W-1:0]  paddr     = '0;
    logic [DATA_W-1:0]  pwdata    = '0;
    logic               in_stall;
    logic               out_valid;
    t_out_item          out_data;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    logic               calm      = 1'b0;
    int                 cycles    = 0;
    int                 fail_count;
    int                 pending;
    logic [STAMP_W-1:0] ms_clock;
    logic [THR_W-1:0]   cur_thr_l, cur_thr_r;

    edge_avoid_drive_controller dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    eadc_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycles    <= cycles + 1;
        out_stall <= !calm && ($urandom_range(0, 99) < 23);
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_sample(input logic [THR_W-1:0] ls, input logic [THR_W-1:0] rs,
                               input logic [STAMP_W-1:0] stamp);
        t_in_item req;
        req.left_sample  = ls;
        req.right_sample = rs;
        req.now_ms       = stamp;
        while (!calm && $urandom_range(0, 99) < 23) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
    endtask

    // hold off requests until every response is back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic load_settings(input logic [THR_W-1:0] lt, input logic [THR_W-1:0] rt,
                                 input logic [SPD_W-1:0] cs, input logic [SPD_W-1:0] rs,
                                 input logic [SPD_W-1:0] ss, input logic [TIME_W-1:0] bt,
                                 input logic [TIME_W-1:0] tt, input logic [TIME_W-1:0] ct);
        put_reg(REG_LEFT_THR, DATA_W'(lt));
        put_reg(REG_RIGHT_THR, DATA_W'(rt));
        put_reg(REG_CRUISE_SPD, DATA_W'(cs));
        put_reg(REG_REVERSE_SPD, DATA_W'(rs));
        put_reg(REG_SPIN_SPD, DATA_W'(ss));
        put_reg(REG_BACKUP_MS, DATA_W'(bt));
        put_reg(REG_TURN_MS, DATA_W'(tt));
        put_reg(REG_CORNER_MS, DATA_W'(ct));
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        cur_thr_l  = lt;
        cur_thr_r  = rt;
        @(posedge clk);
    endtask

    function automatic logic [THR_W-1:0] reflect_level(input logic [THR_W-1:0] thr,
                                                       input logic hit);
        if (!hit)
            return THR_W'($urandom_range(0, thr));
        if (thr == {THR_W{1'b1}})
            return THR_W'($urandom);
        return THR_W'($urandom_range(thr + 1, 4095));
    endfunction

    task automatic random_sample(input int span);
        int              roll;
        logic [1:0]      side;
        logic [THR_W-1:0] ls, rs;
        roll     = $urandom_range(0, 99);
        ms_clock = ms_clock + $urandom_range(0, span / 6 + 3);
        side     = 2'b00;
        if (roll < 3)
            ms_clock = $urandom;
        if (roll >= 88)
            side = 2'($urandom_range(1, 3));
        if (roll < 15) begin
            ls = THR_W'($urandom);
            rs = THR_W'($urandom);
        end else begin
            ls = reflect_level(cur_thr_l, side[0]);
            rs = reflect_level(cur_thr_r, side[1]);
        end
        send_sample(ls, rs, ms_clock);
    endtask

    initial begin
        logic [TIME_W-1:0] bt, tt, ct;
        logic [THR_W-1:0]  lt, rt;
        int                span;
        cur_thr_l = RST_THR;
        cur_thr_r = RST_THR;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: full left, right and corner walks, wrap of the stamp
        send_sample(12'd0, 12'd0, 32'd0);
        send_sample(12'd3700, 12'd3700, 32'd5);
        send_sample(12'd3701, 12'd0, 32'd10);
        send_sample(12'd0, 12'd0, 32'd310);
        send_sample(12'd4095, 12'd4095, 32'd311);
        send_sample(12'd0, 12'd0, 32'd711);
        send_sample(12'd0, 12'd0, 32'd712);
        send_sample(12'd0, 12'd4095, 32'd800);
        send_sample(12'd0, 12'd0, 32'd1101);
        send_sample(12'd0, 12'd0, 32'd1502);
        send_sample(12'd4095, 12'd3701, 32'hFFFF_FF00);
        send_sample(12'd0, 12'd0, 32'h0000_0030);
        send_sample(12'd0, 12'd0, 32'h0000_0030 + 32'd700);
        send_sample(12'd0, 12'd0, 32'h0000_0030 + 32'd701);
        send_sample(12'd0, 12'd0, 32'h0000_0030 + 32'd702);
        drain();

        // zero thresholds and durations, zero cruise, clamped reverse
        load_settings(12'd0, 12'd0, 7'd0, 7'd127, 7'd100, 16'd0, 16'd0, 16'd0);
        send_sample(12'd0, 12'd0, 32'd1000);
        send_sample(12'd1, 12'd0, 32'd1001);
        send_sample(12'd0, 12'd0, 32'd1001);
        send_sample(12'd0, 12'd0, 32'd1002);
        send_sample(12'd0, 12'd0, 32'd1003);
        send_sample(12'd0, 12'd0, 32'd1004);
        drain();

        // full left and zero right threshold, full durations, zero reverse, clamped spin
        load_settings(12'd4095, 12'd0, 7'd1, 7'd0, 7'd127, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(12'd4095, 12'd0, 32'd5000);
        send_sample(12'd4095, 12'd1, 32'd5001);
        send_sample(12'd0, 12'd0, 32'd5001 + 32'd65535);
        send_sample(12'd0, 12'd0, 32'd5001 + 32'd65536);
        send_sample(12'd0, 12'd0, 32'd5001 + 32'd131072);
        drain();

        ms_clock = $urandom;
        for (int p = 0; p < RAND_PHASES; p++) begin
            bt   = (p == 3) ? TIME_W'($urandom_range(1000, 65535))
                            : TIME_W'($urandom_range(0, 25));
            tt   = (p == 3) ? TIME_W'($urandom_range(1000, 65535))
                            : TIME_W'($urandom_range(0, 25));
            ct   = (p == 3) ? TIME_W'($urandom_range(1000, 65535))
                            : TIME_W'($urandom_range(0, 25));
            lt   = (p == 4) ? ($urandom_range(0, 1) ? 12'd4095 : 12'd0)
                            : THR_W'($urandom_range(1500, 4000));
            rt   = (p == 4) ? ($urandom_range(0, 1) ? 12'd4095 : 12'd0)
                            : THR_W'($urandom_range(1500, 4000));
            span = bt;
            if (tt > span)
                span = tt;
            if (ct > span)
                span = ct;
            load_settings(lt, rt, SPD_W'($urandom_range(0, 127)),
                          SPD_W'($urandom_range(0, 127)), SPD_W'($urandom_range(0, 127)),
                          bt, tt, ct);
            // one whole phase with no gaps and no stalls
            calm <= (p == 2);
            repeat (PHASE_REQS) random_sample(span);
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
